@@ rtl/core/jpbs_pkg.sv @@
// Package for the Jacobi Poisson block solver: payload types, opcodes and defaults.
package jpbs_pkg;

  localparam int GRID_SIZE_DEF = 8;
  localparam int VAL_W         = 32;
  localparam int CNT_W         = 16;

  localparam logic [2:0] OP_LOAD_POT = 3'd0;
  localparam logic [2:0] OP_LOAD_SRC = 3'd1;
  localparam logic [2:0] OP_LOAD_FACE = 3'd2;
  localparam logic [2:0] OP_RUN      = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  typedef struct packed {
    logic [2:0]              op;
    logic [2:0]              coord_x;
    logic [2:0]              coord_y;
    logic [2:0]              coord_z;
    logic [2:0]              face_select;
    logic signed [VAL_W-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    run_done;
  } out_item_t;

endpackage

@@ rtl/core/jpbs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module jpbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/jacobi_poisson_block_solver.sv @@
// Top level of the Jacobi Poisson block solver: sequencer, datapath and stores.
// Load and unused items: result registered at the accept edge.
// Read items: one RAM read, then the result register.
// Run items: sweep_count sweeps over the grid; a zero count gives run_done at the accept edge.
//   Each point reads six neighbors, then the source, divides by six and writes back.
// Reset clears the sequencer, output valid, the bank select and sets sweep_count
//   to one; the grids and faces stay undefined until written.
module jacobi_poisson_block_solver #(
  parameter int GRID_SIZE = jpbs_pkg::GRID_SIZE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  jpbs_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output jpbs_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);
  import jpbs_pkg::*;

  localparam int PLANE = GRID_SIZE * GRID_SIZE;
  localparam int CELLS = PLANE * GRID_SIZE;
  localparam int FACES = 6 * PLANE;
  localparam int AW    = $clog2(CELLS);
  localparam int FAW   = $clog2(FACES);
  localparam int CW    = $clog2(GRID_SIZE);
  localparam int ACC_W = 36;
  localparam int DIV_W = 40;
  localparam int DIG_W = 20;
  localparam int DV_W  = DIG_W + 3;
  localparam int DIV_STEPS = DIV_W / DIG_W;
  localparam int RECIP_SH  = 24;
  localparam logic [21:0] RECIP6 = 22'd2796203;
  localparam logic [CW-1:0] CMAX = CW'(GRID_SIZE - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_WAIT, ST_SWEEP, ST_DIV, ST_WRITE
  } state_e;

  // Which store the read in flight came from.
  typedef enum logic [1:0] {SEL_POT, SEL_FACE, SEL_SRC} sel_e;

  state_e                 state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;
  logic [CNT_W-1:0]       sweep_count_q;
  logic [CNT_W-1:0]       sweep_ctr_q, sweep_ctr_d;
  logic                   bank_q, bank_d;
  logic                   rd_ok_q, rd_ok_d;
  logic [CW-1:0]          sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  logic [AW-1:0]          pidx_q, pidx_d;
  logic [2:0]             step_q, step_d;
  logic [3:0]             dcnt_q, dcnt_d;
  sel_e                   sel_q, sel_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [DIV_W-1:0]       div_q, div_d;
  logic [2:0]             rem_q, rem_d;
  logic [VAL_W-1:0]       sat_res;

  // RAM ports
  logic            pot_we [2];
  logic [AW-1:0]   pot_waddr;
  logic [VAL_W-1:0] pot_wdata;
  logic [AW-1:0]   pot_raddr;
  logic [VAL_W-1:0] pot_rdata [2];
  logic            src_we;
  logic [AW-1:0]   src_raddr;
  logic [VAL_W-1:0] src_rdata;
  logic            face_we;
  logic [FAW-1:0]  face_waddr, face_raddr;
  logic [VAL_W-1:0] face_rdata;

  logic            accept;
  logic            pt_ok;
  logic [AW-1:0]   in_idx;
  logic [VAL_W-1:0] cur_pot;
  logic [VAL_W-1:0] rd_data;
  logic signed [ACC_W-1:0] contrib;
  logic signed [DIV_W:0]   qs;
  logic            last_pt;

  function automatic logic [FAW-1:0] face_addr(input int f, input logic [CW-1:0] a,
                                               input logic [CW-1:0] b);
    face_addr = FAW'(f * PLANE) + FAW'(b) * FAW'(GRID_SIZE) + FAW'(a);
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pt_ok = (int'(in_data_i.coord_x) < GRID_SIZE) && (int'(in_data_i.coord_y) < GRID_SIZE)
              && (int'(in_data_i.coord_z) < GRID_SIZE);
  assign in_idx = AW'(in_data_i.coord_z) * AW'(PLANE) + AW'(in_data_i.coord_y) * AW'(GRID_SIZE)
                + AW'(in_data_i.coord_x);

  assign cur_pot = bank_q ? pot_rdata[1] : pot_rdata[0];

  // Write ports: loads hit the live bank, sweep results the other one.
  always_comb begin
    logic load_pot;
    logic sw_wr;
    load_pot = accept && (in_data_i.op == OP_LOAD_POT) && pt_ok;
    sw_wr    = (state_q == ST_WRITE);
    pot_we[0] = (load_pot && !bank_q) || (sw_wr && bank_q);
    pot_we[1] = (load_pot && bank_q) || (sw_wr && !bank_q);
    pot_waddr = sw_wr ? pidx_q : in_idx;
    pot_wdata = sw_wr ? sat_res : in_data_i.load_value;
  end

  assign src_we     = accept && (in_data_i.op == OP_LOAD_SRC) && pt_ok;
  assign face_we    = accept && (in_data_i.op == OP_LOAD_FACE)
                   && (in_data_i.face_select < 3'd6)
                   && (int'(in_data_i.coord_x) < GRID_SIZE)
                   && (int'(in_data_i.coord_y) < GRID_SIZE);
  assign face_waddr = FAW'(in_data_i.face_select) * FAW'(PLANE)
                    + FAW'(in_data_i.coord_y) * FAW'(GRID_SIZE) + FAW'(in_data_i.coord_x);
  assign src_raddr  = pidx_q;

  // Stencil read issue: one neighbor per step, source last.
  always_comb begin
    pot_raddr  = pidx_q;
    face_raddr = '0;
    sel_d      = sel_q;
    if (state_q == ST_IDLE) begin
      pot_raddr = in_idx;
    end else begin
      case (step_q)
        3'd0: begin
          if (sx_q == CMAX) begin
            face_raddr = face_addr(0, sy_q, sz_q); sel_d = SEL_FACE;
          end else begin
            pot_raddr = pidx_q + AW'(1); sel_d = SEL_POT;
          end
        end
        3'd1: begin
          if (sx_q == '0) begin
            face_raddr = face_addr(1, sy_q, sz_q); sel_d = SEL_FACE;
          end else begin
            pot_raddr = pidx_q - AW'(1); sel_d = SEL_POT;
          end
        end
        3'd2: begin
          if (sy_q == CMAX) begin
            face_raddr = face_addr(2, sx_q, sz_q); sel_d = SEL_FACE;
          end else begin
            pot_raddr = pidx_q + AW'(GRID_SIZE); sel_d = SEL_POT;
          end
        end
        3'd3: begin
          if (sy_q == '0) begin
            face_raddr = face_addr(3, sx_q, sz_q); sel_d = SEL_FACE;
          end else begin
            pot_raddr = pidx_q - AW'(GRID_SIZE); sel_d = SEL_POT;
          end
        end
        3'd4: begin
          if (sz_q == CMAX) begin
            face_raddr = face_addr(4, sx_q, sy_q); sel_d = SEL_FACE;
          end else begin
            pot_raddr = pidx_q + AW'(PLANE); sel_d = SEL_POT;
          end
        end
        3'd5: begin
          if (sz_q == '0) begin
            face_raddr = face_addr(5, sx_q, sy_q); sel_d = SEL_FACE;
          end else begin
            pot_raddr = pidx_q - AW'(PLANE); sel_d = SEL_POT;
          end
        end
        default: sel_d = SEL_SRC;
      endcase
    end
  end

  // Data of the read issued in the cycle before, signed into the accumulator width; source negated.
  always_comb begin
    case (sel_q)
      SEL_FACE: rd_data = face_rdata;
      SEL_SRC:  rd_data = src_rdata;
      default:  rd_data = cur_pot;
    endcase
    contrib = ACC_W'(signed'(rd_data));
    if (sel_q == SEL_SRC) begin
      contrib = -contrib;
    end
  end

  assign last_pt = (sx_q == CMAX) && (sy_q == CMAX) && (sz_q == CMAX);
  assign qs = signed'({1'b0, div_q}) - (DIV_W+1)'(64'd1 << 36);

  always_comb begin
    logic [DV_W-1:0]    dv;
    logic [DV_W+21:0]   prod;
    logic [DIG_W-1:0]   dq;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    sweep_ctr_d = sweep_ctr_q;
    bank_d      = bank_q;
    rd_ok_d     = rd_ok_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sz_d        = sz_q;
    pidx_d      = pidx_q;
    step_d      = step_q;
    dcnt_d      = dcnt_q;
    acc_d       = acc_q;
    div_d       = div_q;
    rem_d       = rem_q;
    dv          = '0;
    prod        = '0;
    dq          = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d = '0;
          if (in_data_i.op == OP_READ) begin
            rd_ok_d = pt_ok;
            state_d = ST_RD_WAIT;
          end else if (in_data_i.op == OP_RUN) begin
            sweep_ctr_d = '0;
            if (sweep_count_q == '0) begin
              out_d.run_done = 1'b1;
              out_valid_d    = 1'b1;
            end else begin
              sx_d = '0; sy_d = '0; sz_d = '0;
              pidx_d = '0; step_d = '0;
              state_d = ST_SWEEP;
            end
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_RD_WAIT: begin
        out_d.read_value = rd_ok_q ? signed'(cur_pot) : '0;
        out_valid_d      = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_SWEEP: begin
        acc_d  = (step_q == 3'd0) ? '0 : acc_q + contrib;
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) begin
          // Bias keeps the dividend positive; it is removed after the divide.
          div_d  = DIV_W'(acc_d) + DIV_W'(3) + (DIV_W'(6) << 36);
          rem_d  = '0;
          dcnt_d = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // One 20-bit digit per cycle: reciprocal multiply for the quotient digit,
        // subtract for the remainder; quotient digits shift in at the bottom.
        dv     = {rem_q, div_q[DIV_W-1 -: DIG_W]};
        prod   = dv * RECIP6;
        dq     = prod[RECIP_SH +: DIG_W];
        div_d  = {div_q[DIV_W-DIG_W-1:0], dq};
        rem_d  = 3'(dv - DV_W'(dq) * DV_W'(6));
        dcnt_d = dcnt_q + 4'd1;
        if (dcnt_q == 4'(DIV_STEPS - 1)) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        step_d = '0;
        state_d = ST_SWEEP;
        if (sx_q == CMAX) begin
          sx_d = '0;
          if (sy_q == CMAX) begin
            sy_d = '0;
            sz_d = sz_q + CW'(1);
          end else begin
            sy_d = sy_q + CW'(1);
          end
        end else begin
          sx_d = sx_q + CW'(1);
        end
        pidx_d = pidx_q + AW'(1);
        if (last_pt) begin
          sz_d   = '0;
          pidx_d = '0;
          bank_d = !bank_q;
          sweep_ctr_d = sweep_ctr_q + CNT_W'(1);
          if ((sweep_ctr_q + CNT_W'(1)) >= sweep_count_q) begin
            out_d       = '0;
            out_d.run_done = 1'b1;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Saturate the unbiased quotient to the signed 32-bit range.
  always_comb begin
    if (qs > (DIV_W+1)'(64'sd2147483647)) begin
      sat_res = 32'h7fff_ffff;
    end else if (qs < -(DIV_W+1)'(64'sd2147483648)) begin
      sat_res = 32'h8000_0000;
    end else begin
      sat_res = qs[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      sweep_count_q <= CNT_W'(1);
      sweep_ctr_q   <= '0;
      bank_q        <= 1'b0;
      step_q        <= '0;
      dcnt_q        <= '0;
      sel_q         <= SEL_POT;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        sweep_count_q <= cfg_wdata_i;
      end
      sweep_ctr_q <= sweep_ctr_d;
      bank_q      <= bank_d;
      step_q      <= step_d;
      dcnt_q      <= dcnt_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    rd_ok_q <= rd_ok_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    sz_q    <= sz_d;
    pidx_q  <= pidx_d;
    acc_q   <= acc_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
  end

  for (genvar b = 0; b < 2; b++) begin : g_pot
    jpbs_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_pot (
      .clk_i   (clk_i),
      .we_i    (pot_we[b]),
      .waddr_i (pot_waddr),
      .wdata_i (pot_wdata),
      .raddr_i (pot_raddr),
      .rdata_o (pot_rdata[b])
    );
  end

  jpbs_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_src (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (in_idx),
    .wdata_i (in_data_i.load_value),
    .raddr_i (src_raddr),
    .rdata_o (src_rdata)
  );

  jpbs_ram #(.WIDTH(VAL_W), .DEPTH(FACES)) u_face (
    .clk_i   (clk_i),
    .we_i    (face_we),
    .waddr_i (face_waddr),
    .wdata_i (in_data_i.load_value),
    .raddr_i (face_raddr),
    .rdata_o (face_rdata)
  );

endmodule

@@ tb/jacobi_poisson_block_solver_checker.sv @@
`timescale 1ns / 100ps
// Checker for the Jacobi Poisson block solver: watches both channels, predicts results, compares.
module jacobi_poisson_block_solver_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  jpbs_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  jpbs_pkg::out_item_t out_data_i,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  output int                  pending_o,
  output int                  fail_count_o
);
  import jpbs_pkg::*;

  localparam int N     = GRID_SIZE_DEF;
  localparam int PLANE = N * N;
  localparam int CELLS = N * N * N;

  logic signed [31:0] potential_q [CELLS];
  logic signed [31:0] scratch_q   [CELLS];
  logic signed [31:0] source_q    [CELLS];
  logic signed [31:0] faces_q     [6 * PLANE];
  logic [15:0]        sweeps_per_run;
  out_item_t          expected_results [$];

  assign pending_o = expected_results.size();

  function automatic longint point_value(int x, int y, int z);
    if (x < 0) return faces_q[1 * PLANE + z * N + y];
    if (x >= N) return faces_q[0 * PLANE + z * N + y];
    if (y < 0) return faces_q[3 * PLANE + z * N + x];
    if (y >= N) return faces_q[2 * PLANE + z * N + x];
    if (z < 0) return faces_q[5 * PLANE + y * N + x];
    if (z >= N) return faces_q[4 * PLANE + y * N + x];
    return potential_q[z * PLANE + y * N + x];
  endfunction

  // Round to nearest, ties up, then clamp to 32 bits.
  function automatic logic signed [31:0] sixth_clamped(longint s);
    longint t;
    longint q;
    t = s + 3;
    if (t >= 0) q = t / 6;
    else q = -((-t + 5) / 6);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  task automatic jacobi_sweep();
    longint s;
    for (int z = 0; z < N; z++)
      for (int y = 0; y < N; y++)
        for (int x = 0; x < N; x++) begin
          s = point_value(x + 1, y, z) + point_value(x - 1, y, z)
            + point_value(x, y + 1, z) + point_value(x, y - 1, z)
            + point_value(x, y, z + 1) + point_value(x, y, z - 1)
            - longint'(source_q[z * PLANE + y * N + x]);
          scratch_q[z * PLANE + y * N + x] = sixth_clamped(s);
        end
    potential_q = scratch_q;
  endtask

  task automatic predict_item(in_item_t it);
    out_item_t r;
    int idx;
    r   = '0;
    idx = it.coord_z * PLANE + it.coord_y * N + it.coord_x;
    case (it.op)
      OP_LOAD_POT: potential_q[idx] = it.load_value;
      OP_LOAD_SRC: source_q[idx] = it.load_value;
      OP_LOAD_FACE: begin
        if (it.face_select < 6)
          faces_q[it.face_select * PLANE + it.coord_y * N + it.coord_x] = it.load_value;
      end
      OP_RUN: begin
        for (int k = 0; k < sweeps_per_run; k++) jacobi_sweep();
        r.run_done = 1'b1;
      end
      OP_READ: r.read_value = potential_q[idx];
      default: ;
    endcase
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      sweeps_per_run = 16'd1;
      expected_results.delete();
    end else begin
      // Compare first: a result never belongs to the transfer at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 0, 1);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, out_data_i.read_value);
          if (out_data_i.run_done !== want.run_done)
            report_mismatch("run_done", want.run_done, out_data_i.run_done);
        end
      end
      if (in_valid_i && in_ready_i) predict_item(in_data_i);
      if (cfg_we_i) sweeps_per_run = cfg_wdata_i;
    end
  end
endmodule

@@ tb/jacobi_poisson_block_solver_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the Jacobi Poisson block solver: stimulus, back-pressure and verdict.
module jacobi_poisson_block_solver_test;
  import jpbs_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_data_o;
  logic                cfg_we_i;
  logic [15:0]         cfg_wdata_i;
  int                  pending;
  int                  fail_count;
  longint              cycles;
  bit                  no_gaps;
  int                  n_items, n_runs, n_reads;

  jacobi_poisson_block_solver u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  jacobi_poisson_block_solver_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bail out on a hung handshake or a runaway run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver back-pressure: mostly ready, short random stalls, now and then a long one.
  int stall_left = 0;
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(99);
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (no_gaps) begin
      out_ready_i <= 1'b1;
    end else if (r < 2) begin
      stall_left  <= $urandom_range(60, 15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (r < 75);
    end
  end

  // Sender gap: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 45) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Mostly small Q16.16 values so sweeps stay in range; extremes force saturation.
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $signed($urandom_range(16, 0) - 8) <<< 16 ^ $urandom_range(16'hffff);
    if (r < 60) return 32'h7fffffff;
    if (r < 70) return 32'h80000000;
    if (r < 75) return 32'h0;
    return $urandom;
  endfunction

  // Hold valid and payload until the transfer; valid stays high across back-to-back items.
  task automatic send_item(logic [2:0] op, int x, int y, int z, int f, logic [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    in_data_i.op          <= op;
    in_data_i.coord_x     <= x[2:0];
    in_data_i.coord_y     <= y[2:0];
    in_data_i.coord_z     <= z[2:0];
    in_data_i.face_select <= f[2:0];
    in_data_i.load_value  <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_items++;
    if (op == OP_RUN) n_runs++;
    if (op == OP_READ) n_reads++;
  endtask

  // Drop valid, wait for every outstanding result, then let the datapath settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_sweeps(logic [15:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_item(int run_odds);
    int r;
    r = $urandom_range(999);
    if (r < run_odds)
      send_item(OP_RUN, $urandom_range(7), $urandom_range(7), $urandom_range(7),
                $urandom_range(7), $urandom);
    else if (r < 250)
      send_item(OP_LOAD_POT, $urandom_range(7), $urandom_range(7), $urandom_range(7),
                $urandom_range(7), pick_value());
    else if (r < 400)
      send_item(OP_LOAD_SRC, $urandom_range(7), $urandom_range(7), $urandom_range(7),
                $urandom_range(7), pick_value());
    else if (r < 600)
      send_item(OP_LOAD_FACE, $urandom_range(7), $urandom_range(7), $urandom_range(7),
                $urandom_range(7), pick_value());
    else if (r < 950)
      send_item(OP_READ, $urandom_range(7), $urandom_range(7), $urandom_range(7),
                $urandom_range(7), $urandom);
    else
      send_item($urandom_range(7, 5), $urandom_range(7), $urandom_range(7),
                $urandom_range(7), $urandom_range(7), $urandom);
  endtask

  initial begin
    cycles      = 0;
    no_gaps     = 1'b0;
    n_items     = 0;
    n_runs      = 0;
    n_reads     = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_ready_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_sweeps(16'd2);

    // Fill every store so no sweep or read touches an unwritten entry.
    for (int i = 0; i < 512; i++) begin
      send_item(OP_LOAD_POT, i % 8, (i / 8) % 8, i / 64, $urandom_range(7), pick_value());
      send_item(OP_LOAD_SRC, i % 8, (i / 8) % 8, i / 64, $urandom_range(7), pick_value());
    end
    for (int i = 0; i < 384; i++)
      send_item(OP_LOAD_FACE, i % 8, (i / 8) % 8, $urandom_range(7), i / 64, pick_value());

    // Directed: extreme values at corners, ignored face selects, unused opcodes, a run, reads.
    send_item(OP_LOAD_POT, 0, 0, 0, 0, 32'h7fffffff);
    send_item(OP_LOAD_POT, 7, 7, 7, 7, 32'h80000000);
    send_item(OP_LOAD_SRC, 7, 0, 7, 0, 32'h80000000);
    send_item(OP_LOAD_FACE, 7, 7, 7, 0, 32'h7fffffff);
    send_item(OP_LOAD_FACE, 0, 0, 0, 5, 32'h80000000);
    send_item(OP_LOAD_FACE, 3, 4, 0, 6, 32'h12345678);
    send_item(OP_LOAD_FACE, 4, 3, 7, 7, 32'hdeadbeef);
    send_item(OP_READ, 0, 0, 0, 0, 32'h0);
    send_item(OP_READ, 7, 7, 7, 7, 32'hffffffff);
    send_item(3'd5, 7, 7, 7, 7, 32'hffffffff);
    send_item(3'd6, 0, 0, 0, 0, 32'h0);
    send_item(3'd7, 5, 2, 6, 3, $urandom);
    send_item(OP_RUN, 0, 0, 0, 0, 32'h0);
    send_item(OP_READ, 0, 0, 0, 0, 32'h0);
    send_item(OP_READ, 7, 7, 7, 0, 32'h0);
    send_item(OP_READ, 3, 5, 1, 0, 32'h0);

    // Hold the sender until the block has drained, then a zero-sweep run.
    write_sweeps(16'd0);
    send_item(OP_RUN, 7, 7, 7, 7, 32'hffffffff);
    send_item(OP_READ, 1, 2, 3, 0, 32'h0);

    // Largest sweep count: no runs while it is set, only loads, reads and unused opcodes.
    write_sweeps(16'hffff);
    for (int i = 0; i < 20; i++) random_item(0);
    write_sweeps(16'd1);

    // Random traffic; a stretch of it runs with no idling on either side.
    for (int i = 0; i < 150; i++) begin
      if (i == 50) no_gaps = 1'b1;
      if (i == 90) no_gaps = 1'b0;
      if (i == 100) write_sweeps(16'd2);
      random_item(40);
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("covered %0d transfers: %0d sweep runs, %0d reads, sweep counts 0, 1, 2, max",
             n_items, n_runs, n_reads);
    $display("with random sender gaps and receiver stalls, %0d mismatches", fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/jpbs_pkg.sv
rtl/core/jpbs_ram.sv
rtl/core/jacobi_poisson_block_solver.sv
tb/jacobi_poisson_block_solver_checker.sv
tb/jacobi_poisson_block_solver_test.sv
